### hw/rtl/assert_macros.svh
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled on clk, off during reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ds2_pkg.sv
// Shared constants and types of the 2x2 box downsampler.
package ds2_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int CHANNEL_BITS = 16;
    localparam int NUM_LANES    = 4;

    localparam int SUM_BITS   = CHANNEL_BITS + 1;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int PCOL_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam int CFG_W_BITS     = 12;
    localparam int CFG_H_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int PROW_BITS      = CFG_H_BITS - 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [SUM_BITS-1:0]     pair_t;

    typedef struct packed {
        logic                 take;
        logic                 w_one;
        logic                 x_odd;
        logic                 h_one;
        logic                 wr_en;
        logic                 rd_en;
        logic [PCOL_BITS-1:0] pcol;
    } lane_ctl_t;

endpackage

### hw/rtl/ds2_pix_if.sv
// Input pixel stream channel.
interface ds2_pix_if import ds2_pkg::*;;
    logic  valid;
    logic  ready;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
    chan_t in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

### hw/rtl/ds2_res_if.sv
// Downsampled pixel result channel.
interface ds2_res_if import ds2_pkg::*;;
    logic  valid;
    logic  ready;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
    logic  out_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output out_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input out_last, output ready);
endinterface

### hw/rtl/ds2_cfg_if.sv
// Configuration register write channel.
interface ds2_cfg_if import ds2_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ds2_ram.sv
// Generic simple dual-port RAM with registered read.
module ds2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ds2_lane.sv
// One channel lane: horizontal pair sum, line buffer, vertical sum and average.
module ds2_lane import ds2_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  chan_t     px,
    output chan_t     avg
);

    chan_t                held_reg;
    pair_t                pair;
    pair_t                pair_s1_reg;
    pair_t                up_sum;
    logic [SUM_BITS:0]    vsum;

    assign pair = ctl.w_one ? {px, 1'b0} : SUM_BITS'(held_reg) + SUM_BITS'(px);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctl.take && !ctl.x_odd)
        begin
            held_reg <= px;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            pair_s1_reg <= pair;
        end
    end

    ds2_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (ctl.pcol),
        .wr_data (pair),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.pcol),
        .rd_data (up_sum)
    );

    assign vsum = ctl.h_one ? {pair_s1_reg, 1'b0}
                            : (SUM_BITS + 1)'(up_sum) + (SUM_BITS + 1)'(pair_s1_reg);
    assign avg  = vsum[SUM_BITS:2];

endmodule

### hw/rtl/ds2_seq.sv
// Image geometry registers, raster position and lane control.
module ds2_seq import ds2_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ds2_cfg_if.sink      cfg,
    input  logic         accept,
    output lane_ctl_t    ctl,
    output logic         emit,
    output logic         last
);

    localparam logic [CFG_W_BITS-1:0] MAX_W = CFG_W_BITS'(MAX_WIDTH);

    logic [COL_BITS-1:0]   w_last_reg,    w_last_next;
    logic                  w_one_reg,     w_one_next;
    logic [PCOL_BITS-1:0]  pcol_last_reg, pcol_last_next;
    logic [CFG_H_BITS-1:0] h_last_reg,    h_last_next;
    logic                  h_one_reg,     h_one_next;
    logic [PROW_BITS-1:0]  prow_last_reg, prow_last_next;
    logic [COL_BITS-1:0]   x_reg,         x_next;
    logic [CFG_H_BITS-1:0] y_reg,         y_next;

    logic                  cfg_wr;
    logic [CFG_W_BITS-1:0] w_eff, w_two;
    logic [CFG_H_BITS-1:0] h_eff, h_two;
    logic                  have_pair;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        w_eff = cfg.data[CFG_W_BITS-1:0];
        if (w_eff == '0)
        begin
            w_eff = CFG_W_BITS'(1);
        end
        else if (w_eff > MAX_W)
        begin
            w_eff = MAX_W;
        end
        w_two = (w_eff < CFG_W_BITS'(2)) ? CFG_W_BITS'(2) : w_eff;
        h_eff = (cfg.data[CFG_H_BITS-1:0] == '0) ? CFG_H_BITS'(1) : cfg.data[CFG_H_BITS-1:0];
        h_two = (h_eff < CFG_H_BITS'(2)) ? CFG_H_BITS'(2) : h_eff;

        w_last_next    = w_last_reg;
        w_one_next     = w_one_reg;
        pcol_last_next = pcol_last_reg;
        h_last_next    = h_last_reg;
        h_one_next     = h_one_reg;
        prow_last_next = prow_last_reg;
        if (cfg_wr)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:
                begin
                    w_last_next    = COL_BITS'(w_eff - CFG_W_BITS'(1));
                    w_one_next     = (w_eff == CFG_W_BITS'(1));
                    pcol_last_next = PCOL_BITS'((w_two >> 1) - CFG_W_BITS'(1));
                end
                CFG_IMAGE_HEIGHT:
                begin
                    h_last_next    = h_eff - CFG_H_BITS'(1);
                    h_one_next     = (h_eff == CFG_H_BITS'(1));
                    prow_last_next = PROW_BITS'((h_two >> 1) - CFG_H_BITS'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    // any recognized register write restarts the image
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cfg_wr && (cfg.index == CFG_IMAGE_WIDTH || cfg.index == CFG_IMAGE_HEIGHT))
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (accept)
        begin
            if (x_reg == w_last_reg)
            begin
                x_next = '0;
                y_next = (y_reg == h_last_reg) ? '0 : y_reg + CFG_H_BITS'(1);
            end
            else
            begin
                x_next = x_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= COL_BITS'(MAX_WIDTH - 1);
            w_one_reg     <= 1'b0;
            pcol_last_reg <= PCOL_BITS'(MAX_WIDTH / 2 - 1);
            h_last_reg    <= '0;
            h_one_reg     <= 1'b1;
            prow_last_reg <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            w_last_reg    <= w_last_next;
            w_one_reg     <= w_one_next;
            pcol_last_reg <= pcol_last_next;
            h_last_reg    <= h_last_next;
            h_one_reg     <= h_one_next;
            prow_last_reg <= prow_last_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
        end
    end

    assign have_pair = w_one_reg || x_reg[0];

    assign ctl.take  = accept;
    assign ctl.w_one = w_one_reg;
    assign ctl.x_odd = x_reg[0];
    assign ctl.h_one = h_one_reg;
    assign ctl.wr_en = accept && have_pair && !h_one_reg && !y_reg[0];
    assign ctl.rd_en = accept && have_pair && !h_one_reg && y_reg[0];
    assign ctl.pcol  = PCOL_BITS'(x_reg >> 1);

    assign emit = accept && have_pair && (h_one_reg || y_reg[0]);
    assign last = (ctl.pcol == pcol_last_reg) && (y_reg[CFG_H_BITS-1:1] == prow_last_reg);

endmodule

### hw/rtl/box_downsample_2x2_unit.sv
// Top level of the 2x2 box downsampler: lanes, pipeline control and result register.
// Takes one RGBA pixel per clock in raster order, while results are taken, and emits one
// averaged pixel for each 2x2 block, on the pixel that completes the block; that result
// passes through one lane stage with the line-buffer read, then one result register.
// The sustained rate is one pixel per cycle unless result backpressure stalls the input;
// each of the four channel lanes owns a 1024 x 17 buffer of pair sums from the even rows,
// written and read once per cycle at most. The buffer needs no clearing after reset.
// Dimensions of 0 count as 1, widths above 2048 as 2048; a dimension of 1 reuses its
// edge, an odd last column or row is dropped. Writing either register restarts the image.
`include "assert_macros.svh"

module box_downsample_2x2_unit import ds2_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ds2_pix_if.sink   pixel,
    ds2_res_if.source result,
    ds2_cfg_if.sink   cfg
);

    lane_ctl_t ctl;
    logic      accept;
    logic      emit;
    logic      last;
    logic      s1_adv;
    chan_t     px  [NUM_LANES];
    chan_t     avg [NUM_LANES];

    logic      s1_valid_reg,  s1_valid_next;
    logic      s1_last_reg;
    logic      out_valid_reg, out_valid_next;
    logic      out_last_reg;
    chan_t     out_chan_reg [NUM_LANES];

    assign s1_adv      = !out_valid_reg || result.ready;
    assign pixel.ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel.valid && pixel.ready;

    assign px[0] = pixel.in_red;
    assign px[1] = pixel.in_green;
    assign px[2] = pixel.in_blue;
    assign px[3] = pixel.in_alpha;

    ds2_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .ctl    (ctl),
        .emit   (emit),
        .last   (last)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        ds2_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .px    (px[i]),
            .avg   (avg[i])
        );
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= last;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_last_reg <= s1_last_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                out_chan_reg[i] <= avg[i];
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_red   = out_chan_reg[0];
    assign result.out_green = out_chan_reg[1];
    assign result.out_blue  = out_chan_reg[2];
    assign result.out_alpha = out_chan_reg[3];
    assign result.out_last  = out_last_reg;

    `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg, "s1 beat lost")
    `ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_valid_reg && s1_adv, out_valid_reg, "s1 beat stuck")
    `ASSERT_HOLDS(a_line_port, clk, rst_n, !(ctl.wr_en && ctl.rd_en), "line port conflict")

endmodule

### sim/box_downsample_2x2_unit_test.sv
// Testbench for box_downsample_2x2_unit: directed and random images checked against a predictor.
module box_downsample_2x2_unit_test;
    import ds2_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_PIXELS  = 700;
    localparam int WIDE_PIXELS    = 300;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = CFG_INDEX_BITS'(9);

    typedef logic [SUM_BITS+1:0] acc_t;

    typedef struct {
        chan_t ch [NUM_LANES];
        logic  last;
    } down_px_t;

    logic clk;
    logic rst_n;

    ds2_pix_if pixel_if ();
    ds2_res_if result_if ();
    ds2_cfg_if cfg_if ();

    box_downsample_2x2_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // predictor state
    logic [CFG_W_BITS-1:0] cfg_width  = CFG_W_BITS'(2048);
    logic [CFG_H_BITS-1:0] cfg_height = CFG_H_BITS'(1);
    int unsigned           col_pos    = 0;
    int unsigned           row_pos    = 0;
    chan_t                 held_px   [NUM_LANES] = '{default: '0};
    pair_t                 even_row_sums [NUM_LANES][LINE_DEPTH];

    down_px_t expected_q [$];

    int  mismatches  = 0;
    int  pixels_in   = 0;
    int  results_out = 0;
    int  cfg_writes  = 0;
    int  idle_cycles = 0;
    int  ready_hold  = 0;
    bit  burst_mode  = 0;

    string lane_name [NUM_LANES] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst_mode || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(80, 20);
    endfunction

    function automatic chan_t rand_chan();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return chan_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_pixel(input chan_t px [NUM_LANES]);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned pcol;
        acc_t        pair [NUM_LANES];
        acc_t        sum  [NUM_LANES];
        bit          have_pair;
        bit          emit;
        down_px_t    exp_px;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        ow = ((w < 2) ? 2 : w) / 2;
        oh = ((h < 2) ? 2 : h) / 2;
        pcol = col_pos / 2;
        have_pair = 0;
        emit = 0;
        for (int lane = 0; lane < NUM_LANES; lane++)
        begin
            pair[lane] = '0;
            sum[lane]  = '0;
        end
        if (w == 1)
        begin
            for (int lane = 0; lane < NUM_LANES; lane++)
                pair[lane] = acc_t'(px[lane]) << 1;
            have_pair = 1;
        end
        else if (col_pos[0] == 1'b0)
        begin
            if (col_pos + 1 < w)
                held_px = px;
        end
        else
        begin
            for (int lane = 0; lane < NUM_LANES; lane++)
                pair[lane] = acc_t'(held_px[lane]) + acc_t'(px[lane]);
            have_pair = 1;
        end
        if (have_pair)
        begin
            if (h == 1)
            begin
                for (int lane = 0; lane < NUM_LANES; lane++)
                    sum[lane] = pair[lane] << 1;
                emit = 1;
            end
            else if (row_pos[0] == 1'b0)
            begin
                if (row_pos + 1 < h)
                    for (int lane = 0; lane < NUM_LANES; lane++)
                        even_row_sums[lane][pcol] = pair_t'(pair[lane]);
            end
            else
            begin
                for (int lane = 0; lane < NUM_LANES; lane++)
                    sum[lane] = acc_t'(even_row_sums[lane][pcol]) + pair[lane];
                emit = 1;
            end
        end
        if (emit)
        begin
            for (int lane = 0; lane < NUM_LANES; lane++)
                exp_px.ch[lane] = chan_t'(sum[lane] >> 2);
            exp_px.last = (pcol == ow - 1) && (row_pos / 2 == oh - 1);
            expected_q.push_back(exp_px);
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    // beat monitor: config, pixels, results
    always @(posedge clk)
    begin
        chan_t    px  [NUM_LANES];
        chan_t    got [NUM_LANES];
        down_px_t exp_px;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                cfg_writes++;
                if (cfg_if.index == CFG_IMAGE_WIDTH)
                begin
                    cfg_width = cfg_if.data[CFG_W_BITS-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                else if (cfg_if.index == CFG_IMAGE_HEIGHT)
                begin
                    cfg_height = cfg_if.data[CFG_H_BITS-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (pixel_if.valid && pixel_if.ready)
            begin
                px = '{pixel_if.in_red, pixel_if.in_green, pixel_if.in_blue, pixel_if.in_alpha};
                pixels_in++;
                predict_pixel(px);
            end
            if (result_if.valid && result_if.ready)
            begin
                results_out++;
                if (expected_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    exp_px = expected_q.pop_front();
                    got = '{result_if.out_red, result_if.out_green, result_if.out_blue,
                            result_if.out_alpha};
                    for (int lane = 0; lane < NUM_LANES; lane++)
                        if (got[lane] !== exp_px.ch[lane])
                            report_mismatch($sformatf("%s got %h expected %h",
                                            lane_name[lane], got[lane], exp_px.ch[lane]));
                    if (result_if.out_last !== exp_px.last)
                        report_mismatch($sformatf("out_last got %b expected %b",
                                        result_if.out_last, exp_px.last));
                end
            end
        end
    end

    // result backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
        begin
            result_if.ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            result_if.ready <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_if.valid && pixel_if.ready) || (result_if.valid && result_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b, input chan_t a);
        int gap;
        pixel_if.valid    <= 1'b1;
        pixel_if.in_red   <= r;
        pixel_if.in_green <= g;
        pixel_if.in_blue  <= b;
        pixel_if.in_alpha <= a;
        do
            @(posedge clk);
        while (!pixel_if.ready);
        gap = pick_gap();
        if (gap != 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    // waits for the pipeline to drain so a register write lands while idle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        pixel_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA);
        send_pixel(16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_edge_clamp();
        set_size(1, 1);
        send_pixel(16'hFFFF, 16'h0001, 16'h8000, 16'h0003);
        set_size(0, 0);
        send_pixel(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0002);
        set_size(1, 3);
        send_random_pixels(3);
        set_size(5, 1);
        send_random_pixels(5);
    endtask

    task automatic test_unused_index();
        set_size(2, 2);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_UNUSED_INDEX, 16'h0003);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_restart();
        set_size(2, 4);
        send_random_pixels(1);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_random_pixels(4);
    endtask

    task automatic test_size_extremes();
        set_size(16'hFFFF, 1);
        send_random_pixels(2);
        set_size(1, 16'hFFFF);
        send_random_pixels(3);
        set_size(2048, 2);
        send_random_pixels(WIDE_PIXELS);
    endtask

    task automatic test_random_images();
        int sent;
        int w;
        int h;
        int npix;
        int reps;
        int r;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            r = $urandom_range(99);
            if (r < 3)
                w = 0;
            else if (r < 12)
                w = 1;
            else if (r < 88)
                w = $urandom_range(9, 2);
            else
                w = $urandom_range(64, 10);
            r = $urandom_range(99);
            if (r < 3)
                h = 0;
            else if (r < 12)
                h = 1;
            else if (r < 92)
                h = $urandom_range(9, 2);
            else
                h = $urandom_range(20, 10);
            if ($urandom_range(1))
                set_size({4'($urandom), 12'(w)}, 16'(h));
            else
            begin
                write_reg(CFG_IMAGE_HEIGHT, 16'(h));
                write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
            end
            burst_mode = ($urandom_range(4) == 0);
            npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            reps = ($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1;
            if ($urandom_range(9) == 0)
                npix = $urandom_range(npix);
            else
                npix = npix * reps;
            if (npix > RANDOM_PIXELS - sent)
                npix = RANDOM_PIXELS - sent;
            send_random_pixels(npix);
            sent += npix;
        end
        burst_mode = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_if.valid    <= 1'b0;
        pixel_if.in_red   <= '0;
        pixel_if.in_green <= '0;
        pixel_if.in_blue  <= '0;
        pixel_if.in_alpha <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_edge_clamp();
        test_unused_index();
        test_restart();
        test_size_extremes();
        test_random_images();

        pixel_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input pixels and %0d register writes; %0d downsampled pixels",
                 pixels_in, cfg_writes, results_out);
        $display("checked, including edge clamps, odd sizes, restarts and 2048-wide rows; %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
